FILE: rtl/txdrm_pkg.sv
// Package for the transmit descriptor ring manager.
// Holds the queue geometry, the status codes and the sequencer state type; no dependencies.
`timescale 1ns / 1ps

package txdrm_pkg;

  localparam int QUEUE_DEPTH  = 8;
  localparam int BUFFER_BYTES = 2048;
  localparam int HEADER_BYTES = 12;

  localparam int IDX_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int LEN_W   = 16;
  localparam int ID_W    = 16;
  localparam int CNT_W   = 16;
  localparam int SLOT_W  = 8;
  localparam int BYTES_W = 12;
  localparam int SUM_W   = LEN_W + 1;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_TOO_LONG    = 3'd1,
    ST_NO_FREE     = 3'd2,
    ST_BAD_ID      = 3'd3,
    ST_DOUBLE_FREE = 3'd4
  } status_e;

  typedef enum logic [0:0] {
    OP_SEND    = 1'b0,
    OP_RECLAIM = 1'b1
  } op_e;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_SCAN = 4'b0100,
    S_OUT  = 4'b1000
  } state_e;

endpackage

FILE: rtl/tx_descriptor_ring_manager.sv
// Transmit descriptor ring manager top level: sequencer, free-map scan unit and result register.
// Depends on txdrm_pkg.
`timescale 1ns / 1ps

// Driver-side bookkeeping for a split-ring transmit queue. A send item (operation 0) checks
// that header plus packet fits one buffer, then walks the free map one descriptor per cycle
// from descriptor 0 with a single compare unit, takes the lowest free one, places it at avail
// ring position avail_index modulo the queue depth, advances avail_index and raises notify.
// A reclaim item (operation 1) flags an out-of-range id or a double free, else frees the
// descriptor and advances used_index. One item is handled at a time: in_ready_o is high only
// while the block is idle. A reclaim or an oversized send is resolved without a scan, while a
// send that finds descriptor k free walks descriptors 0 to k first (all of them when the ring
// is full). The result then waits in an output register until taken, and the block is ready
// again on the cycle after that.
module tx_descriptor_ring_manager
  import txdrm_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [0:0]           operation_i,
  input  logic [LEN_W-1:0]     packet_length_i,
  input  logic [ID_W-1:0]      completed_id_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [2:0]           status_o,
  output logic [SLOT_W-1:0]    descriptor_slot_o,
  output logic [SLOT_W-1:0]    ring_slot_o,
  output logic [BYTES_W-1:0]   descriptor_bytes_o,
  output logic [CNT_W-1:0]     avail_count_o,
  output logic [CNT_W-1:0]     used_count_o,
  output logic                 notify_o
);

  // Control state
  state_e                 state_q, state_d;
  logic [QUEUE_DEPTH-1:0] free_q, free_d;
  logic [IDX_W-1:0]       idx_q, idx_d;
  logic [IDX_W-1:0]       ring_q, ring_d;
  logic [CNT_W-1:0]       avail_q, avail_d;
  logic [CNT_W-1:0]       used_q, used_d;

  // Latched item and result payload
  op_e                    op_q;
  logic [LEN_W-1:0]       len_q;
  logic [ID_W-1:0]        id_q;
  status_e                status_q, status_d;
  logic [SLOT_W-1:0]      desc_q, desc_d;
  logic [SLOT_W-1:0]      rslot_q, rslot_d;
  logic [BYTES_W-1:0]     bytes_q, bytes_d;
  logic                   notify_q, notify_d;

  logic                   in_fire;
  logic [SUM_W-1:0]       total;
  logic                   too_long;
  logic                   id_bad;
  logic [IDX_W-1:0]       id_idx;

  assign in_fire  = in_valid_i && in_ready_o;
  assign total    = {1'b0, len_q} + SUM_W'(HEADER_BYTES);
  assign too_long = total > SUM_W'(BUFFER_BYTES);
  assign id_bad   = id_q >= ID_W'(QUEUE_DEPTH);
  assign id_idx   = id_q[IDX_W-1:0];

  always_comb begin
    state_d  = state_q;
    free_d   = free_q;
    idx_d    = idx_q;
    ring_d   = ring_q;
    avail_d  = avail_q;
    used_d   = used_q;
    status_d = status_q;
    desc_d   = desc_q;
    rslot_d  = rslot_q;
    bytes_d  = bytes_q;
    notify_d = notify_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        // Resolve everything that needs no scan; otherwise start the walk at descriptor 0.
        rslot_d  = '0;
        bytes_d  = '0;
        notify_d = 1'b0;
        desc_d   = '0;
        if (op_q == OP_RECLAIM) begin
          desc_d  = id_q[SLOT_W-1:0];
          state_d = S_OUT;
          if (id_bad) begin
            status_d = ST_BAD_ID;
          end else if (free_q[id_idx]) begin
            status_d = ST_DOUBLE_FREE;
          end else begin
            status_d       = ST_OK;
            free_d[id_idx] = 1'b1;
            used_d         = used_q + CNT_W'(1);
          end
        end else if (too_long) begin
          status_d = ST_TOO_LONG;
          state_d  = S_OUT;
        end else begin
          idx_d   = '0;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        // Test one descriptor per cycle; stop at the first free one.
        if (free_q[idx_q]) begin
          free_d[idx_q] = 1'b0;
          status_d      = ST_OK;
          desc_d        = SLOT_W'(idx_q);
          rslot_d       = SLOT_W'(ring_q);
          bytes_d       = total[BYTES_W-1:0];
          notify_d      = 1'b1;
          avail_d       = avail_q + CNT_W'(1);
          // Track avail_index modulo the depth; the 16-bit wrap restarts it at zero.
          if (avail_q == {CNT_W{1'b1}} || ring_q == IDX_W'(QUEUE_DEPTH - 1)) begin
            ring_d = '0;
          end else begin
            ring_d = ring_q + IDX_W'(1);
          end
          state_d = S_OUT;
        end else if (idx_q == IDX_W'(QUEUE_DEPTH - 1)) begin
          status_d = ST_NO_FREE;
          state_d  = S_OUT;
        end else begin
          idx_d = idx_q + IDX_W'(1);
        end
      end
      S_OUT: begin
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      free_q  <= '1;
      idx_q   <= '0;
      ring_q  <= '0;
      avail_q <= '0;
      used_q  <= '0;
    end else begin
      state_q <= state_d;
      free_q  <= free_d;
      idx_q   <= idx_d;
      ring_q  <= ring_d;
      avail_q <= avail_d;
      used_q  <= used_d;
    end
  end

  // Hold the item and the result payload; no reset needed.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q  <= op_e'(operation_i);
      len_q <= packet_length_i;
      id_q  <= completed_id_i;
    end
    status_q <= status_d;
    desc_q   <= desc_d;
    rslot_q  <= rslot_d;
    bytes_q  <= bytes_d;
    notify_q <= notify_d;
  end

  assign in_ready_o         = (state_q == S_IDLE);
  assign out_valid_o        = (state_q == S_OUT);
  assign status_o           = status_q;
  assign descriptor_slot_o  = desc_q;
  assign ring_slot_o        = rslot_q;
  assign descriptor_bytes_o = bytes_q;
  assign avail_count_o      = avail_q;
  assign used_count_o       = used_q;
  assign notify_o           = notify_q;

  // A result never shares a cycle with an open input.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("input open while a result is pending");

  // Notify only accompanies a successful allocation.
  a_notify_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && notify_o) |-> (status_o == ST_OK && descriptor_bytes_o != '0))
    else $error("notify without a successful send");

  // The avail index moves only as the scan allocates a descriptor.
  a_avail_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (avail_q != $past(avail_q)) |-> ($past(state_q) == S_SCAN && out_valid_o && notify_o))
    else $error("avail index changed outside an allocation");

  // The used index advances only with a successful reclaim.
  a_used_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (used_q != $past(used_q)) |-> (out_valid_o && status_o == ST_OK && !notify_o))
    else $error("used index changed outside a reclaim");

endmodule
